// ===== src/osp_pkg.sv =====
// ----------------------------------------------------------------------------
// osp_pkg: shared types and constants for the ordered set predecessor block
// Bitmap geometry, command codes, sequencer states and the bitmap port bundle.
// ----------------------------------------------------------------------------
package osp_pkg;

   localparam int MAX_INDEX  = 1024;
   localparam int INDEX_W    = 11;                 // command index / count field
   localparam int PRED_W     = 10;                 // result field
   localparam int POS_W      = $clog2(MAX_INDEX);  // zero-based position
   localparam int BIT_SEL_W  = 5;
   localparam int WORD_W     = 1 << BIT_SEL_W;
   localparam int WORD_SEL_W = POS_W - BIT_SEL_W;
   localparam int NUM_WORDS  = MAX_INDEX / WORD_W;

   localparam logic [INDEX_W-1:0] MAX_INDEX_V = INDEX_W'(MAX_INDEX);
   localparam logic [INDEX_W-1:0] COUNT_RESET = INDEX_W'(1024);

   typedef enum logic {
      CMD_REMOVE = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW,
      ST_Q_WORD,
      ST_Q_SUM,
      ST_Q_ALT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [WORD_SEL_W-1:0] rd_addr;
      logic                  wr_en;
      logic [WORD_SEL_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } map_req_type;

endpackage

// ===== src/osp_msb.sv =====
// ----------------------------------------------------------------------------
// osp_msb: highest set bit finder
// Shared search unit; binary-halving tree over one bitmap word.
// ----------------------------------------------------------------------------
module osp_msb (
   input  logic [osp_pkg::WORD_W-1:0]    vec,
   output logic                          found,
   output logic [osp_pkg::BIT_SEL_W-1:0] idx
);
   import osp_pkg::*;

   logic [WORD_W-1:0] stage [BIT_SEL_W+1];

   always_comb begin
      stage[0] = vec;
      for (int lvl = 0; lvl < BIT_SEL_W; lvl++) begin
         // keep the upper half when it has any bit, else the lower half
         idx[BIT_SEL_W-1-lvl] = |(stage[lvl] >> (WORD_W >> (lvl + 1)));
         stage[lvl+1] = idx[BIT_SEL_W-1-lvl] ? (stage[lvl] >> (WORD_W >> (lvl + 1)))
                                              : stage[lvl];
      end
      found = |vec;
   end

endmodule

// ===== src/osp_map.sv =====
// ----------------------------------------------------------------------------
// osp_map: removed-index bitmap
// Word memory with registered read, row valid bits and a per-word full summary.
// ----------------------------------------------------------------------------
module osp_map (
   input  logic                        clock,
   input  logic                        reset,
   input  osp_pkg::map_req_type        req,
   output logic [osp_pkg::WORD_W-1:0]  rd_data,
   output logic [osp_pkg::NUM_WORDS-1:0] full
);
   import osp_pkg::*;

   logic [WORD_W-1:0]    mem [NUM_WORDS];
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic [NUM_WORDS-1:0] full_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         full_ff      <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (req.wr_en) begin
            row_valid_ff[req.wr_addr] <= 1'b1;
            full_ff[req.wr_addr]      <= &req.wr_data;
         end
         if (req.rd_en) begin
            rd_valid_ff <= row_valid_ff[req.rd_addr];
         end
      end
   end

   // never-written rows read as nothing removed
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;
   assign full    = full_ff;

endmodule

// ===== src/ordered_set_predecessor.sv =====
// ----------------------------------------------------------------------------
// ordered_set_predecessor: bitmap predecessor search
// Keeps the set 1..n minus removed indices; answers largest present index below x.
//
//   channel   ports                                  direction
//   req       req_valid req_stall req_command req_index   in
//   rsp       rsp_valid rsp_stall rsp_predecessor         out
//   csr       csr_valid csr_ready csr_active_count        in
//
// Remove: read, then modify-write; an out-of-range remove is ignored.
// Query: a word search, then the response; a trivial query goes straight
// to the response, and a miss in the first word goes through the 32-bit full
// summary and one more bitmap read, all through one shared bit finder.
// req_stall is high while an item is in work or its response waits.
// Synchronous reset; no clearing pass, rows are tracked by valid bits.
// ----------------------------------------------------------------------------
module ordered_set_predecessor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [osp_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [osp_pkg::PRED_W-1:0]    rsp_predecessor,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [osp_pkg::INDEX_W-1:0]   csr_active_count
);
   import osp_pkg::*;

   state_type            state_ff, state_in;
   logic [INDEX_W-1:0]   count_ff;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [PRED_W-1:0]    pred_ff, pred_in;

   map_req_type          map_req;
   logic [WORD_W-1:0]    rd_data;
   logic [NUM_WORDS-1:0] full;

   logic [WORD_W-1:0]    enc_vec;
   logic                 enc_found;
   logic [BIT_SEL_W-1:0] enc_idx;

   logic [INDEX_W-1:0]   x_clip, n_clip, x_m1, top;
   logic                 trivial, rm_ok;
   logic [WORD_W-1:0]    bit_mask;
   logic [NUM_WORDS-1:0] word_mask;
   logic [POS_W:0]       hit_value;

   osp_map u_map (
      .clock   (clock),
      .reset   (reset),
      .req     (map_req),
      .rd_data (rd_data),
      .full    (full)
   );

   osp_msb u_msb (
      .vec   (enc_vec),
      .found (enc_found),
      .idx   (enc_idx)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_active_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      pred_ff <= pred_in;
   end

   // query window: top present candidate is min(x-1, n)
   always_comb begin
      x_clip  = (req_index > MAX_INDEX_V) ? MAX_INDEX_V : req_index;
      n_clip  = (count_ff > MAX_INDEX_V) ? MAX_INDEX_V : count_ff;
      x_m1    = x_clip - INDEX_W'(1);
      top     = (x_m1 < n_clip) ? x_m1 : n_clip;
      trivial = (x_clip <= INDEX_W'(1)) || (n_clip == '0);
      rm_ok   = (req_index != '0) && (req_index <= MAX_INDEX_V);
   end

   always_comb begin
      for (int k = 0; k < WORD_W; k++) begin
         bit_mask[k] = (BIT_SEL_W'(k) <= pos_ff[BIT_SEL_W-1:0]);
      end
      for (int k = 0; k < NUM_WORDS; k++) begin
         word_mask[k] = (WORD_SEL_W'(k) < pos_ff[POS_W-1:BIT_SEL_W]);
      end
   end

   // bit finder input, selected by the search step
   always_comb begin
      case (state_ff)
         ST_Q_WORD: enc_vec = ~rd_data & bit_mask;
         // words below the start word lie fully inside 1..n
         ST_Q_SUM:  enc_vec = ~full & word_mask;
         ST_Q_ALT:  enc_vec = ~rd_data;
         default:   enc_vec = '0;
      endcase
   end

   assign hit_value = {pos_ff[POS_W-1:BIT_SEL_W], enc_idx} + (POS_W+1)'(1);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      pred_in   = pred_ff;
      map_req   = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == CMD_REMOVE) begin
                  if (rm_ok) begin
                     pos_in          = POS_W'(req_index - INDEX_W'(1));
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = pos_in[POS_W-1:BIT_SEL_W];
                     state_in        = ST_RMW;
                  end
               end else if (trivial) begin
                  pred_in  = '0;
                  state_in = ST_RESP;
               end else begin
                  pos_in          = POS_W'(top - INDEX_W'(1));
                  map_req.rd_en   = 1'b1;
                  map_req.rd_addr = pos_in[POS_W-1:BIT_SEL_W];
                  state_in        = ST_Q_WORD;
               end
            end
         end
         ST_RMW: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = pos_ff[POS_W-1:BIT_SEL_W];
            map_req.wr_data = rd_data | (WORD_W'(1) << pos_ff[BIT_SEL_W-1:0]);
            state_in        = ST_IDLE;
         end
         ST_Q_WORD: begin
            if (enc_found) begin
               pred_in  = PRED_W'(hit_value);
               state_in = ST_RESP;
            end else begin
               state_in = ST_Q_SUM;
            end
         end
         ST_Q_SUM: begin
            if (enc_found) begin
               pos_in          = {enc_idx, {BIT_SEL_W{1'b0}}};
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = enc_idx;
               state_in        = ST_Q_ALT;
            end else begin
               pred_in  = '0;
               state_in = ST_RESP;
            end
         end
         ST_Q_ALT: begin
            pred_in  = PRED_W'(hit_value);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_predecessor = pred_ff;

endmodule
